// ===== design/tps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

	localparam int QUEUE_DEPTH  = 64;
	localparam int MAX_DISPATCH = 16;

	// command codes
	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_UNREG = 2'd1;
	localparam logic [1:0] CMD_SCALE = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_DISPATCH  = 3'd0;
	localparam logic [2:0] KIND_DONE      = 3'd1;
	localparam logic [2:0] KIND_NONE_DUE  = 3'd2;
	localparam logic [2:0] KIND_FULL      = 3'd3;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd4;

	localparam logic [8:0] SCALE_MAX = 9'd256;

	typedef struct packed {
		logic [31:0] due;
		logic [31:0] last_run;
		logic [7:0]  id;
		logic [15:0] mn;
		logic [15:0] mx;
		logic [8:0]  scale;
		logic        live;
	} entry_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_KILL,
		OP_SCALE
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t   op;
		entry_t     ent;
		logic [7:0] id;
		logic [8:0] scale;
	} cell_ctrl_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  task_out;
		logic [31:0] elapsed;
		logic [31:0] next_due;
		logic        last;
	} result_t;

	// queue order: due time, then smaller id, then dead before live
	function automatic logic ent_precedes(entry_t a, entry_t b);
		logic r;
		if (a.due != b.due) r = a.due < b.due;
		else if (a.id != b.id) r = a.id < b.id;
		else r = !a.live && b.live;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/tps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  task_id;
	logic [31:0] time_now;
	logic [15:0] min_interval;
	logic [15:0] max_interval;
	logic [8:0]  scale;

	modport source (output valid, command, task_id, time_now, min_interval, max_interval,
		scale, input ready);
	modport sink (input valid, command, task_id, time_now, min_interval, max_interval,
		scale, output ready);
endinterface

interface tps_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  task_out;
	logic [31:0] elapsed;
	logic [31:0] next_due;
	logic        last;

	modport source (output valid, kind, task_out, elapsed, next_due, last, input ready);
	modport sink (input valid, kind, task_out, elapsed, next_due, last, output ready);
endinterface
`default_nettype wire

// ===== design/tps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tps_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire tps_pkg::cell_ctrl_t ctrl,
	input  wire tps_pkg::entry_t     left_ent,
	input  wire                      left_vld,
	input  wire                      left_gt,
	input  wire tps_pkg::entry_t     right_ent,
	input  wire                      right_vld,
	output tps_pkg::entry_t          own_ent,
	output logic                     own_vld,
	output logic                     own_gt,
	output logic                     own_match
);
	import tps_pkg::*;

	entry_t ent_q;
	logic   vld_q;

	assign own_ent   = ent_q;
	assign own_vld   = vld_q;
	// new item belongs at or before this cell
	assign own_gt    = !vld_q || ent_precedes(ctrl.ent, ent_q);
	assign own_match = vld_q && ent_q.live && (ent_q.id == ctrl.id);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_POP: vld_q <= right_vld;
				OP_INSERT: begin
					if (left_gt) vld_q <= left_vld;
					else if (own_gt) vld_q <= 1'b1;
				end
				default: vld_q <= vld_q;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_POP: ent_q <= right_ent;
			OP_INSERT: begin
				if (left_gt) ent_q <= left_ent;
				else if (own_gt) ent_q <= ctrl.ent;
			end
			OP_KILL: if (own_match) ent_q.live <= 1'b0;
			OP_SCALE: if (own_match) ent_q.scale <= ctrl.scale;
			default: ent_q <= ent_q;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/timed_priority_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timed task scheduler kept as a sorted row of cells, earliest due task in cell 0.
// in_ch carries commands (register, unregister, set scale, tick); out_ch carries
// result items, the final one of each command flagged by last. cfg_we/cfg_wdata
// set the dispatch budget (reset 16); the user must write it only while the block
// is idle, which the block itself does not enforce. Commands are taken one at a
// time: in_ch.ready is high only when idle, and the next command is accepted at
// the earliest at the edge where the final result of the previous one can first
// be taken. Register decodes, then inserts; unregister and set scale finish in
// the decode step. A tick steps through decode, final check, close and output;
// each dispatched task is popped and put back, and each dead entry at the top
// is dropped. A result is held back in a pending register so that last can be
// set on the final one.
// Every cell compares the key on the insert broadcast in parallel and hands its
// entry to a neighbor, so each queue update is one parallel write of the row.
// Reset empties the queue at once (valid bit per cell) and restores the budget.
// A stalled receiver holds the output register; a tick's put-back waits while
// the held-back result is full and the output register is full and stalled.
module timed_priority_scheduler (
	input  wire        clk,
	input  wire        arst_n,
	tps_in_if.sink     in_ch,
	tps_out_if.source  out_ch,
	input  wire        cfg_we,
	input  wire [4:0]  cfg_wdata
);
	import tps_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_INS  = 6'b000100,
		S_TICK = 6'b001000,
		S_PUT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_FINAL,
		RD_PEND,
		RD_FLUSH
	} route_t;

	state_t      state_q, state_d;
	logic [4:0]  budget_q;
	logic [1:0]  cmd_q;
	logic [7:0]  id_q;
	logic [31:0] now_q;
	logic [15:0] mn_q, mx_q;
	logic [8:0]  sc_q;
	logic [4:0]  n_q;
	entry_t      reins_q;
	logic [31:0] el_q;
	result_t     o_q, p_q, r;
	logic        ov_q, pv_q;
	route_t      rd;
	cell_ctrl_t  ctrl;
	entry_t      new_ent;
	logic        out_free, can_emit;
	logic [4:0]  bud_eff;

	entry_t                 ent [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld, gt, mt;

	// row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t le, re;
		logic   lv, lg, rv;
		if (i == 0) begin : g_first
			assign le = '0;
			assign lv = 1'b0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign le = ent[i-1];
			assign lv = vld[i-1];
			assign lg = gt[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign re = '0;
			assign rv = 1'b0;
		end else begin : g_next
			assign re = ent[i+1];
			assign rv = vld[i+1];
		end
		tps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_ent  (le),
			.left_vld  (lv),
			.left_gt   (lg),
			.right_ent (re),
			.right_vld (rv),
			.own_ent   (ent[i]),
			.own_vld   (vld[i]),
			.own_gt    (gt[i]),
			.own_match (mt[i])
		);
	end

	assign in_ch.ready     = (state_q == S_IDLE);
	assign out_ch.valid    = ov_q;
	assign out_ch.kind     = o_q.kind;
	assign out_ch.task_out = o_q.task_out;
	assign out_ch.elapsed  = o_q.elapsed;
	assign out_ch.next_due = o_q.next_due;
	assign out_ch.last     = o_q.last;

	assign out_free = !ov_q || out_ch.ready;
	assign can_emit = !pv_q || out_free;
	assign bud_eff  = (budget_q == 5'd0) ? 5'd1 :
		(budget_q > 5'(MAX_DISPATCH)) ? 5'(MAX_DISPATCH) : budget_q;

	always_comb begin
		new_ent          = '0;
		new_ent.due      = now_q + {16'd0, mn_q};
		new_ent.last_run = now_q;
		new_ent.id       = id_q;
		new_ent.mn       = mn_q;
		new_ent.mx       = mx_q;
		new_ent.scale    = sc_q;
		new_ent.live     = 1'b1;
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		ctrl.op    = OP_HOLD;
		ctrl.ent   = new_ent;
		ctrl.id    = id_q;
		ctrl.scale = sc_q;
		rd         = RD_NONE;
		r          = '0;
		r.task_out = id_q;
		r.last     = 1'b1;
		case (state_q)
			S_IDLE: if (in_ch.valid) state_d = S_EXEC;
			S_EXEC: begin
				case (cmd_q)
					CMD_REG: begin
						if (vld[QUEUE_DEPTH-1]) begin
							if (out_free) begin
								r.kind  = KIND_FULL;
								rd      = RD_FINAL;
								state_d = S_IDLE;
							end
						end else begin
							ctrl.op = OP_KILL;
							state_d = S_INS;
						end
					end
					CMD_UNREG, CMD_SCALE: begin
						if (out_free) begin
							ctrl.op = (cmd_q == CMD_UNREG) ? OP_KILL : OP_SCALE;
							r.kind  = (|mt) ? KIND_DONE : KIND_NOT_FOUND;
							rd      = RD_FINAL;
							state_d = S_IDLE;
						end
					end
					default: state_d = S_TICK;
				endcase
			end
			S_INS: begin
				if (out_free) begin
					ctrl.op    = OP_INSERT;
					r.kind     = KIND_DONE;
					r.next_due = new_ent.due;
					rd         = RD_FINAL;
					state_d    = S_IDLE;
				end
			end
			S_TICK: begin
				if (vld[0] && (ent[0].due < now_q)) begin
					if (!ent[0].live) ctrl.op = OP_POP;
					else if (n_q >= bud_eff) state_d = S_FIN;
					else begin
						ctrl.op = OP_POP;
						state_d = S_PUT;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_PUT: begin
				ctrl.ent = reins_q;
				if (can_emit) begin
					ctrl.op    = OP_INSERT;
					r.kind     = KIND_DISPATCH;
					r.task_out = reins_q.id;
					r.elapsed  = el_q;
					r.next_due = reins_q.due;
					r.last     = 1'b0;
					rd         = RD_PEND;
					state_d    = S_TICK;
				end
			end
			S_FIN: begin
				if (out_free) begin
					r.kind  = KIND_NONE_DUE;
					rd      = (n_q == 5'd0) ? RD_FINAL : RD_FLUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// put-back entry for the task at the top
	logic [15:0] span;
	logic [23:0] prod;
	logic [16:0] ival;
	entry_t      put_ent;
	always_comb begin
		span = ent[0].mx - ent[0].mn;
		prod = {8'd0, span} * {15'd0, ent[0].scale};
		ival = (ent[0].mx <= ent[0].mn) ? {1'b0, ent[0].mn} :
			{1'b0, ent[0].mn} + {1'b0, prod[23:8]};
		put_ent          = ent[0];
		put_ent.due      = now_q + {15'd0, ival};
		put_ent.last_run = now_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			budget_q <= 5'd16;
			n_q      <= 5'd0;
			ov_q     <= 1'b0;
			pv_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) budget_q <= cfg_wdata;
			if (state_q == S_EXEC) n_q <= 5'd0;
			else if (rd == RD_PEND) n_q <= n_q + 5'd1;
			ov_q <= (ov_q && !out_ch.ready) || (rd == RD_FINAL) || (rd == RD_FLUSH) ||
				((rd == RD_PEND) && pv_q);
			case (rd)
				RD_FINAL, RD_FLUSH: pv_q <= 1'b0;
				RD_PEND: pv_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q <= in_ch.command;
			id_q  <= in_ch.task_id;
			now_q <= in_ch.time_now;
			mn_q  <= in_ch.min_interval;
			mx_q  <= in_ch.max_interval;
			sc_q  <= (in_ch.scale > SCALE_MAX) ? SCALE_MAX : in_ch.scale;
		end
		if (state_q == S_TICK) begin
			reins_q <= put_ent;
			el_q    <= now_q - ent[0].last_run;
		end
		case (rd)
			RD_FINAL: o_q <= r;
			RD_FLUSH: o_q <= '{kind: p_q.kind, task_out: p_q.task_out,
				elapsed: p_q.elapsed, next_due: p_q.next_due, last: 1'b1};
			RD_PEND: begin
				if (pv_q) o_q <= p_q;
				p_q <= r;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/tps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tps_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [2:0]  kind,
	input wire [7:0]  task_out,
	input wire [31:0] elapsed,
	input wire        last
);
	import tps_pkg::*;

	// one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a command is in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(task_out))
		else $error("stalled result changed");

	// only dispatches can be followed by more results of the same command
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_DISPATCH) |-> last)
		else $error("non-dispatch result not final");

	a_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_DISPATCH) |-> (elapsed == 32'd0))
		else $error("elapsed time on a non-dispatch result");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind <= KIND_NOT_FOUND))
		else $error("undefined result kind");
endmodule

bind timed_priority_scheduler tps_checker u_tps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.kind      (out_ch.kind),
	.task_out  (out_ch.task_out),
	.elapsed   (out_ch.elapsed),
	.last      (out_ch.last)
);
`default_nettype wire

// ===== sim/tb_timed_priority_scheduler.sv =====
`timescale 1ns / 1ps
module tb_timed_priority_scheduler;
	import tps_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  id;
		logic [31:0] now;
		logic [15:0] mn;
		logic [15:0] mx;
		logic [8:0]  sc;
		bit          drain;
	} sched_cmd_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;

	tps_in_if  in_ch ();
	tps_out_if out_ch ();

	timed_priority_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the task queue
	entry_t      sched_slots [QUEUE_DEPTH];
	int unsigned sched_count = 0;
	logic [4:0]  sched_budget;

	sched_cmd_t  pending_cmds [$];
	result_t     due_results [$];
	int          fail_count = 0;
	bit          calm;
	logic [31:0] clock_ms;

	// queue order: due time, smaller id, dead ahead of live
	function automatic bit sched_earlier(int a, int b);
		if (sched_slots[a].due != sched_slots[b].due)
			return sched_slots[a].due < sched_slots[b].due;
		if (sched_slots[a].id != sched_slots[b].id)
			return sched_slots[a].id < sched_slots[b].id;
		return !sched_slots[a].live && sched_slots[b].live;
	endfunction

	function automatic void sched_swap(int a, int b);
		entry_t t;
		t = sched_slots[a];
		sched_slots[a] = sched_slots[b];
		sched_slots[b] = t;
	endfunction

	function automatic void sift_toward_root(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!sched_earlier(i, p)) break;
			sched_swap(i, p);
			i = p;
		end
	endfunction

	function automatic void sift_toward_leaves(int i);
		int l, r, m;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < sched_count && sched_earlier(l, m)) m = l;
			if (r < sched_count && sched_earlier(r, m)) m = r;
			if (m == i) break;
			sched_swap(i, m);
			i = m;
		end
	endfunction

	function automatic int find_live_slot(logic [7:0] id);
		for (int i = 0; i < sched_count; i++)
			if (sched_slots[i].live && sched_slots[i].id == id) return i;
		return -1;
	endfunction

	function automatic void add_result(logic [2:0] kind, logic [7:0] id,
		logic [31:0] el, logic [31:0] nd);
		result_t r;
		r.kind = kind;
		r.task_out = id;
		r.elapsed = el;
		r.next_due = nd;
		r.last = 1'b0;
		due_results.insert(due_results.size(), r);
	endfunction

	// expected results of one accepted command
	function automatic void predict_command(sched_cmd_t c);
		logic [8:0]  sc;
		logic [31:0] span, nd;
		int f, n, budget;
		n = 0;
		sc = (c.sc > SCALE_MAX) ? SCALE_MAX : c.sc;
		case (c.cmd)
			CMD_REG: begin
				if (sched_count >= QUEUE_DEPTH) begin
					add_result(KIND_FULL, c.id, 0, 0);
				end else begin
					f = find_live_slot(c.id);
					if (f >= 0) begin
						sched_slots[f].live = 1'b0;
						sift_toward_root(f);
					end
					sched_slots[sched_count] = '{due: c.now + c.mn, last_run: c.now, id: c.id,
						mn: c.mn, mx: c.mx, scale: sc, live: 1'b1};
					sched_count++;
					sift_toward_root(sched_count - 1);
					add_result(KIND_DONE, c.id, 0, c.now + c.mn);
				end
			end
			CMD_UNREG, CMD_SCALE: begin
				f = find_live_slot(c.id);
				if (f < 0) begin
					add_result(KIND_NOT_FOUND, c.id, 0, 0);
				end else begin
					if (c.cmd == CMD_UNREG) begin
						sched_slots[f].live = 1'b0;
						sift_toward_root(f);
					end else begin
						sched_slots[f].scale = sc;
					end
					add_result(KIND_DONE, c.id, 0, 0);
				end
			end
			default: begin
				budget = sched_budget;
				if (budget < 1) budget = 1;
				if (budget > MAX_DISPATCH) budget = MAX_DISPATCH;
				while (sched_count > 0 && sched_slots[0].due < c.now) begin
					if (!sched_slots[0].live) begin
						// dead entry at the top: drop it quietly
						sched_count--;
						if (sched_count > 0) begin
							sched_swap(0, sched_count);
							sift_toward_leaves(0);
						end
						continue;
					end
					if (n >= budget) break;
					if (sched_slots[0].mx <= sched_slots[0].mn)
						span = sched_slots[0].mn;
					else
						span = sched_slots[0].mn + (((32'(sched_slots[0].mx)
							- 32'(sched_slots[0].mn)) * 32'(sched_slots[0].scale)) >> 8);
					nd = c.now + span;
					add_result(KIND_DISPATCH, sched_slots[0].id,
						c.now - sched_slots[0].last_run, nd);
					n++;
					sched_slots[0].due = nd;
					sched_slots[0].last_run = c.now;
					sift_toward_leaves(0);
				end
				if (n == 0) add_result(KIND_NONE_DUE, c.id, 0, 0);
			end
		endcase
		due_results[due_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void push_cmd(logic [1:0] cmd, logic [7:0] id, logic [31:0] now,
		logic [15:0] mn, logic [15:0] mx, logic [8:0] sc, bit drain);
		sched_cmd_t c;
		c = '{cmd: cmd, id: id, now: now, mn: mn, mx: mx, sc: sc, drain: drain};
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// random traffic around a small id pool, with occasional wide values
	function automatic void add_random_cmds(int n);
		logic [1:0]  cmd;
		logic [7:0]  id;
		logic [15:0] mn, mx;
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			cmd = (p < 35) ? CMD_REG : (p < 50) ? CMD_UNREG : (p < 65) ? CMD_SCALE : CMD_TICK;
			id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
			if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
			else clock_ms = clock_ms + $urandom_range(0, 40);
			mn = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
			mx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
			push_cmd(cmd, id, clock_ms, mn, mx, 9'($urandom_range(0, 511)), i == 0);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command driver
	int in_gap = 0;
	always @(posedge clk) begin
		bit nv;
		sched_cmd_t c;
		if (!arst_n) begin
			nv = 1'b0;
			in_ch.command <= CMD_TICK;
			in_ch.task_id <= '0;
			in_ch.time_now <= '0;
			in_ch.min_interval <= '0;
			in_ch.max_interval <= '0;
			in_ch.scale <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_command(pending_cmds.pop_front());
				nv = 1'b0;
			end else begin
				nv = in_ch.valid;
			end
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_cmds.size() > 0
					&& !(pending_cmds[0].drain && due_results.size() > 0)) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						in_gap = $urandom_range(1, 12);
					end else begin
						c = pending_cmds[0];
						nv = 1'b1;
						in_ch.command <= c.cmd;
						in_ch.task_id <= c.id;
						in_ch.time_now <= c.now;
						in_ch.min_interval <= c.mn;
						in_ch.max_interval <= c.mx;
						in_ch.scale <= c.sc;
					end
				end
			end
		end
		in_ch.valid <= nv;
	end

	// result monitor with random back-pressure
	int out_gap = 0;
	always @(posedge clk) begin
		result_t exp_r;
		if (out_ch.valid && out_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result kind=%0d task=%0d", out_ch.kind, out_ch.task_out);
				fail_count++;
			end else begin
				exp_r = due_results.pop_front();
				if (out_ch.kind !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, out_ch.kind);
					fail_count++;
				end
				if (out_ch.task_out !== exp_r.task_out) begin
					$error("task_out: expected %0d, got %0d", exp_r.task_out, out_ch.task_out);
					fail_count++;
				end
				if (out_ch.elapsed !== exp_r.elapsed) begin
					$error("elapsed: expected %0h, got %0h", exp_r.elapsed, out_ch.elapsed);
					fail_count++;
				end
				if (out_ch.next_due !== exp_r.next_due) begin
					$error("next_due: expected %0h, got %0h", exp_r.next_due, out_ch.next_due);
					fail_count++;
				end
				if (out_ch.last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, out_ch.last);
					fail_count++;
				end
			end
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(1, 12);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("tb_timed_priority_scheduler: done, errors");
			$finish;
		end
	end

	task automatic settle();
		while (pending_cmds.size() > 0 || due_results.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_budget(logic [4:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sched_budget = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [4:0] budgets [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sched_budget = 5'd16;
		calm = 1'b0;
		clock_ms = 32'd1000;
		budgets = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd3};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, the corner cases
		push_cmd(CMD_TICK, 8'd0, 32'd50, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_REG, 8'd0, 32'd100, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_REG, 8'd255, 32'd100, 16'hFFFF, 16'hFFFF, 9'h1FF, 0);
		push_cmd(CMD_REG, 8'd5, 32'd100, 16'd10, 16'd5, 9'd128, 0);
		push_cmd(CMD_REG, 8'd5, 32'd101, 16'd20, 16'd100, 9'd64, 0);
		push_cmd(CMD_REG, 8'd6, 32'd101, 16'd3, 16'd3, 9'd256, 0);
		push_cmd(CMD_UNREG, 8'd6, 32'd102, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_UNREG, 8'd77, 32'd102, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_SCALE, 8'd0, 32'd103, 16'd0, 16'd0, 9'd300, 0);
		push_cmd(CMD_SCALE, 8'd99, 32'd103, 16'd0, 16'd0, 9'd10, 0);
		push_cmd(CMD_TICK, 8'd1, 32'd100, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_TICK, 8'd2, 32'd200, 16'd0, 16'd0, 9'd0, 1);
		push_cmd(CMD_TICK, 8'd3, 32'd400, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_REG, 8'd7, 32'hFFFF_FFF0, 16'd100, 16'd200, 9'd256, 0);
		push_cmd(CMD_REG, 8'd8, 32'hFFFF_FFF0, 16'd5, 16'd10, 9'd0, 0);
		push_cmd(CMD_TICK, 8'd4, 32'hFFFF_FFF8, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_UNREG, 8'd255, 32'hFFFF_FFF8, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_TICK, 8'd255, 32'hFFFF_FFFF, 16'd0, 16'd0, 9'd0, 0);
		push_cmd(CMD_TICK, 8'd9, 32'd300, 16'hFFFF, 16'hFFFF, 9'h1FF, 0);
		add_random_cmds(30);
		settle();

		foreach (budgets[k]) begin
			set_budget(budgets[k]);
			if (k == $size(budgets) - 1) calm = 1'b1;
			if (k == 1 || k == 4) begin
				// fill the queue past its depth, then dispatch in one go
				for (int j = 0; j < 66; j++)
					push_cmd(CMD_REG, 8'(100 + j), clock_ms, 16'd0, 16'd0, 9'd0, j == 0);
				clock_ms = clock_ms + 5;
				push_cmd(CMD_TICK, 8'd0, clock_ms, 16'd0, 16'd0, 9'd0, 1);
				for (int j = 0; j < 40; j++)
					push_cmd(CMD_UNREG, 8'(100 + j), clock_ms, 16'd0, 16'd0, 9'd0, 0);
				clock_ms = clock_ms + 5;
				push_cmd(CMD_TICK, 8'd0, clock_ms, 16'd0, 16'd0, 9'd0, 0);
				add_random_cmds(10);
			end else begin
				add_random_cmds(8);
			end
			settle();
		end

		if (fail_count == 0)
			$display("tb_timed_priority_scheduler: done, clean");
		else
			$display("tb_timed_priority_scheduler: done, errors");
		$finish;
	end

endmodule
